@@ rtl/per_process_mailbox_queues_defines.svh @@
// Assertion macros for the per-process mailbox queues block.
// No dependencies; included by modules that carry assertions.
`ifndef PER_PROCESS_MAILBOX_QUEUES_DEFINES_SVH
`define PER_PROCESS_MAILBOX_QUEUES_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PPMQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PPMQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ppmq_pkg.sv @@
// Shared constants and types for the per-process mailbox queues block.
// No dependencies.
package ppmq_pkg;

  localparam int MAILBOXES   = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int MSG_BYTES   = 8;

  localparam int SLOT_W = 4;
  localparam int PID_W  = 32;
  localparam int SIZE_W = 8;
  localparam int MSZ_W  = 4;
  localparam int PAY_W  = 64;

  localparam int BOX_W  = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;
  localparam int QPOS_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int MADDR_W   = BOX_W + QPOS_W;
  localparam int MSG_DEPTH = 2 ** MADDR_W;

  localparam int IN_DATA_W  = 176;
  localparam int OUT_DATA_W = 136;

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_RECV = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_BOX    = 3'd3,
    ST_FULL      = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  // One stored message.
  typedef struct packed {
    logic [PAY_W-1:0] payload;
    logic [MSZ_W-1:0] size;
    logic [PID_W-1:0] tid;
    logic [PID_W-1:0] pid;
  } msg_t;

endpackage

@@ rtl/ppmq_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ppmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/per_process_mailbox_queues.sv @@
// An early reject goes from accept straight to the registered result; otherwise a tag
// scan (one tag per cycle), a check/update, a RAM read on receive, then the output load.
// One request at a time; the next is taken the cycle after the result registers, and
// a stalled output holds the result and the block until it is taken.
// Reset (rst_n low, synchronous): all mailboxes unbound, output idle; message
// RAM not cleared. Uses ppmq_pkg, ppmq_ram, per_process_mailbox_queues_defines.svh.
module per_process_mailbox_queues (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // proc_slot[3:0], rcv_pid[35:4], receiver_alive[36], src_pid[68:37],
  // src_tid[100:69], send_size[108:101], send_payload[172:109], zero[175:173]
  input  logic [ppmq_pkg::IN_DATA_W-1:0]     in_tdata,
  // cmd[0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status[2:0], msg_src_pid[34:3], msg_src_tid[66:35], msg_size[70:67],
  // msg_payload[134:71], zero[135]
  output logic [ppmq_pkg::OUT_DATA_W-1:0]    out_tdata
);

  import ppmq_pkg::*;

`include "per_process_mailbox_queues_defines.svh"

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_CHECK = 5'b00100,
    S_READ  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  localparam logic [BOX_W-1:0]  BOX_LAST = BOX_W'(MAILBOXES - 1);
  localparam logic [QPOS_W-1:0] Q_LAST   = QPOS_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  Q_FULL   = CNT_W'(QUEUE_DEPTH);

  // Input field breakout
  logic [SLOT_W-1:0] in_slot;
  logic [PID_W-1:0]  in_rpid, in_spid, in_stid;
  logic              in_alive;
  logic [SIZE_W-1:0] in_size;
  logic [PAY_W-1:0]  in_payload;

  assign in_slot    = in_tdata[3:0];
  assign in_rpid    = in_tdata[35:4];
  assign in_alive   = in_tdata[36];
  assign in_spid    = in_tdata[68:37];
  assign in_stid    = in_tdata[100:69];
  assign in_size    = in_tdata[108:101];
  assign in_payload = in_tdata[172:109];

  // Control
  state_t           state_r, state_nxt;
  logic [BOX_W-1:0] scan_r, scan_nxt;
  logic [BOX_W-1:0] box_r, box_nxt;
  logic [BOX_W-1:0] free_r, free_nxt;
  logic             free_found_r, free_found_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Latched request
  logic              req_cmd_r, req_cmd_nxt;
  logic [SLOT_W-1:0] req_slot_r, req_slot_nxt;
  logic [PID_W-1:0]  req_rpid_r, req_rpid_nxt;
  logic [PID_W-1:0]  req_spid_r, req_spid_nxt;
  logic [PID_W-1:0]  req_stid_r, req_stid_nxt;
  logic [MSZ_W-1:0]  req_size_r, req_size_nxt;
  logic [PAY_W-1:0]  req_pay_r, req_pay_nxt;

  // Result staging and output register
  status_t                res_status_r, res_status_nxt;
  msg_t                   res_msg_r, res_msg_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;

  // Box tag table: valid bits reset, the rest is rewritten on binding.
  logic [MAILBOXES-1:0] bound_r;
  logic [SLOT_W-1:0]    slot_r  [MAILBOXES];
  logic [PID_W-1:0]     owner_r [MAILBOXES];
  logic [QPOS_W-1:0]    head_r  [MAILBOXES];
  logic [QPOS_W-1:0]    tail_r  [MAILBOXES];
  logic [CNT_W-1:0]     cnt_r   [MAILBOXES];

  // Single table read port, addressed by the scan index or the chosen box
  logic [BOX_W-1:0]  tr_idx;
  logic              rd_bound;
  logic [SLOT_W-1:0] rd_slot;
  logic [PID_W-1:0]  rd_owner;
  logic [QPOS_W-1:0] rd_head, rd_tail;
  logic [CNT_W-1:0]  rd_cnt;

  // Single table write port
  logic              tw_en;
  logic [BOX_W-1:0]  tw_idx;
  logic [SLOT_W-1:0] tw_slot;
  logic [PID_W-1:0]  tw_owner;
  logic [QPOS_W-1:0] tw_head, tw_tail;
  logic [CNT_W-1:0]  tw_cnt;

  // Message RAM
  logic               ram_we, ram_re;
  logic [MADDR_W-1:0] ram_waddr, ram_raddr;
  msg_t               ram_wdata;
  logic [$bits(msg_t)-1:0] ram_rdata;

  // Check stage: a pid change empties the box before the queue test
  logic              pid_changed;
  logic [QPOS_W-1:0] eff_head, eff_tail;
  logic [CNT_W-1:0]  eff_cnt;
  logic [PAY_W-1:0]  pay_masked;
  logic              in_acc;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign tr_idx   = (state_r == S_SCAN) ? scan_r : box_r;
  assign rd_bound = bound_r[tr_idx];
  assign rd_slot  = slot_r[tr_idx];
  assign rd_owner = owner_r[tr_idx];
  assign rd_head  = head_r[tr_idx];
  assign rd_tail  = tail_r[tr_idx];
  assign rd_cnt   = cnt_r[tr_idx];

  assign pid_changed = (rd_owner != req_rpid_r);
  assign eff_head    = pid_changed ? '0 : rd_head;
  assign eff_tail    = pid_changed ? '0 : rd_tail;
  assign eff_cnt     = pid_changed ? '0 : rd_cnt;

  // bytes at and beyond size are cleared on store
  always_comb begin
    for (int i = 0; i < PAY_W / 8; i++) begin
      pay_masked[i*8 +: 8] = (MSZ_W'(i) < req_size_r) ? req_pay_r[i*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    box_nxt        = box_r;
    free_nxt       = free_r;
    free_found_nxt = free_found_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    req_cmd_nxt    = req_cmd_r;
    req_slot_nxt   = req_slot_r;
    req_rpid_nxt   = req_rpid_r;
    req_spid_nxt   = req_spid_r;
    req_stid_nxt   = req_stid_r;
    req_size_nxt   = req_size_r;
    req_pay_nxt    = req_pay_r;
    res_status_nxt = res_status_r;
    res_msg_nxt    = res_msg_r;

    tw_en    = 1'b0;
    tw_idx   = box_r;
    tw_slot  = rd_slot;
    tw_owner = req_rpid_r;
    tw_head  = eff_head;
    tw_tail  = eff_tail;
    tw_cnt   = eff_cnt;

    ram_we    = 1'b0;
    ram_waddr = {box_r, eff_tail};
    ram_wdata = '{payload: pay_masked, size: req_size_r, tid: req_stid_r, pid: req_spid_r};
    ram_re    = 1'b0;
    ram_raddr = {box_r, eff_head};

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_cmd_nxt    = in_tuser;
          req_slot_nxt   = in_slot;
          req_rpid_nxt   = in_rpid;
          req_spid_nxt   = in_spid;
          req_stid_nxt   = in_stid;
          req_size_nxt   = in_size[MSZ_W-1:0];
          req_pay_nxt    = in_payload;
          res_msg_nxt    = '0;
          scan_nxt       = '0;
          free_found_nxt = 1'b0;
          if (in_tuser == CMD_SEND && in_size == '0) begin
            res_status_nxt = ST_INVALID;
            state_nxt      = S_RESP;
          end else if (in_tuser == CMD_SEND && in_size > SIZE_W'(MSG_BYTES)) begin
            res_status_nxt = ST_TOO_LARGE;
            state_nxt      = S_RESP;
          end else if (!in_alive) begin
            res_status_nxt = ST_INVALID;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_bound && rd_slot == req_slot_r) begin
          box_nxt   = scan_r;
          state_nxt = S_CHECK;
        end else if (scan_r == BOX_LAST) begin
          if (free_found_r || !rd_bound) begin
            // bind the lowest free box to this slot and pid
            box_nxt  = free_found_r ? free_r : scan_r;
            tw_en    = 1'b1;
            tw_idx   = box_nxt;
            tw_slot  = req_slot_r;
            tw_owner = req_rpid_r;
            tw_head  = '0;
            tw_tail  = '0;
            tw_cnt   = '0;
            state_nxt = S_CHECK;
          end else begin
            res_status_nxt = ST_NO_BOX;
            state_nxt      = S_RESP;
          end
        end else begin
          if (!rd_bound && !free_found_r) begin
            free_nxt       = scan_r;
            free_found_nxt = 1'b1;
          end
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_CHECK: begin
        tw_en     = 1'b1;
        state_nxt = S_RESP;
        if (req_cmd_r == CMD_SEND) begin
          if (eff_cnt == Q_FULL) begin
            res_status_nxt = ST_FULL;
          end else begin
            ram_we         = 1'b1;
            tw_tail        = (eff_tail == Q_LAST) ? '0 : eff_tail + 1'b1;
            tw_cnt         = eff_cnt + 1'b1;
            res_status_nxt = ST_OK;
          end
        end else begin
          if (eff_cnt == '0) begin
            res_status_nxt = ST_EMPTY;
          end else begin
            ram_re         = 1'b1;
            tw_head        = (eff_head == Q_LAST) ? '0 : eff_head + 1'b1;
            tw_cnt         = eff_cnt - 1'b1;
            res_status_nxt = ST_OK;
            state_nxt      = S_READ;
          end
        end
      end
      S_READ: begin
        res_msg_nxt = msg_t'(ram_rdata);
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, res_msg_r.payload, res_msg_r.size, res_msg_r.tid,
                           res_msg_r.pid, res_status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
      bound_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
      if (tw_en) begin
        bound_r[tw_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    box_r        <= box_nxt;
    free_r       <= free_nxt;
    req_cmd_r    <= req_cmd_nxt;
    req_slot_r   <= req_slot_nxt;
    req_rpid_r   <= req_rpid_nxt;
    req_spid_r   <= req_spid_nxt;
    req_stid_r   <= req_stid_nxt;
    req_size_r   <= req_size_nxt;
    req_pay_r    <= req_pay_nxt;
    res_status_r <= res_status_nxt;
    res_msg_r    <= res_msg_nxt;
    out_data_r   <= out_data_nxt;
    if (tw_en) begin
      slot_r[tw_idx]  <= tw_slot;
      owner_r[tw_idx] <= tw_owner;
      head_r[tw_idx]  <= tw_head;
      tail_r[tw_idx]  <= tw_tail;
      cnt_r[tw_idx]   <= tw_cnt;
    end
  end

  ppmq_ram #(
    .WIDTH ($bits(msg_t)),
    .DEPTH (MSG_DEPTH)
  ) u_msg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `PPMQ_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_tready, "accepted request did not block input")
  `PPMQ_ASSERT_NOW(a_scan_starts_at_zero, (state_r == S_SCAN) && ($past(state_r) == S_IDLE), scan_r == '0, "scan did not start at box zero")
  `PPMQ_ASSERT_NOW(a_ram_write_only_send, ram_we, (state_r == S_CHECK) && (req_cmd_r == CMD_SEND), "message write outside a send check")
  `PPMQ_ASSERT_NOW(a_count_in_range, state_r == S_CHECK, rd_cnt <= Q_FULL, "mailbox count above queue depth")
  `PPMQ_ASSERT_NOW(a_fail_zero_msg, out_tvalid && (out_tdata[2:0] != ST_OK), out_tdata[134:3] == '0, "failed request returned message data")

endmodule

@@ tb/ppmq_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the per-process mailbox queues block: mirrors the mailbox
// table, predicts the reply to every accepted request and checks each result.
// Depends on ppmq_pkg.
module ppmq_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [ppmq_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [ppmq_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              pending
);

  import ppmq_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [PID_W-1:0] pid;
    logic [PID_W-1:0] tid;
    logic [MSZ_W-1:0] size;
    logic [PAY_W-1:0] payload;
  } reply_t;

  // mirror of the mailbox table
  logic              mb_bound [MAILBOXES];
  logic [SLOT_W-1:0] mb_slot  [MAILBOXES];
  logic [PID_W-1:0]  mb_owner [MAILBOXES];
  logic [QPOS_W-1:0] mb_head  [MAILBOXES];
  logic [QPOS_W-1:0] mb_tail  [MAILBOXES];
  logic [CNT_W-1:0]  mb_count [MAILBOXES];
  msg_t              mb_ring  [MAILBOXES][QUEUE_DEPTH];

  reply_t replies_due [$];
  int     errors = 0;

  function automatic void empty_box(input int b);
    mb_head[b]  = '0;
    mb_tail[b]  = '0;
    mb_count[b] = '0;
  endfunction

  // bound box for the slot (re-tagged and emptied on a pid change), else the
  // lowest free box; -1 when none is left
  function automatic int claim_box(input logic [SLOT_W-1:0] slot,
                                   input logic [PID_W-1:0] pid);
    for (int b = 0; b < MAILBOXES; b++) begin
      if (mb_bound[b] && mb_slot[b] == slot) begin
        if (mb_owner[b] != pid) begin
          empty_box(b);
          mb_owner[b] = pid;
        end
        return b;
      end
    end
    for (int b = 0; b < MAILBOXES; b++) begin
      if (!mb_bound[b]) begin
        empty_box(b);
        mb_bound[b] = 1'b1;
        mb_slot[b]  = slot;
        mb_owner[b] = pid;
        return b;
      end
    end
    return -1;
  endfunction

  task automatic predict_reply(input logic cmd, input logic [IN_DATA_W-1:0] d);
    logic [SLOT_W-1:0] slot;
    logic [PID_W-1:0]  rpid;
    logic [PID_W-1:0]  spid;
    logic [PID_W-1:0]  stid;
    logic              alive;
    logic [SIZE_W-1:0] size;
    logic [PAY_W-1:0]  payload;
    msg_t              m;
    reply_t            r;
    int                b;
    slot    = d[3:0];
    rpid    = d[35:4];
    alive   = d[36];
    spid    = d[68:37];
    stid    = d[100:69];
    size    = d[108:101];
    payload = d[172:109];
    r.status  = ST_OK;
    r.pid     = '0;
    r.tid     = '0;
    r.size    = '0;
    r.payload = '0;
    if (cmd == CMD_SEND) begin
      if (size == 0) begin
        r.status = ST_INVALID;
      end else if (size > MSG_BYTES) begin
        r.status = ST_TOO_LARGE;
      end else if (!alive) begin
        r.status = ST_INVALID;
      end else begin
        b = claim_box(slot, rpid);
        if (b < 0) begin
          r.status = ST_NO_BOX;
        end else if (mb_count[b] >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // bytes past the message length are stored as zero
          if (size < PAY_W / 8) payload &= (PAY_W'(1) << (8 * size)) - PAY_W'(1);
          m.payload = payload;
          m.size    = size[MSZ_W-1:0];
          m.tid     = stid;
          m.pid     = spid;
          mb_ring[b][mb_tail[b]] = m;
          mb_tail[b]  = QPOS_W'((mb_tail[b] + 1) % QUEUE_DEPTH);
          mb_count[b] = mb_count[b] + 1'b1;
        end
      end
    end else begin
      if (!alive) begin
        r.status = ST_INVALID;
      end else begin
        b = claim_box(slot, rpid);
        if (b < 0) begin
          r.status = ST_NO_BOX;
        end else if (mb_count[b] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          m = mb_ring[b][mb_head[b]];
          r.pid     = m.pid;
          r.tid     = m.tid;
          r.size    = m.size;
          r.payload = m.payload;
          mb_head[b]  = QPOS_W'((mb_head[b] + 1) % QUEUE_DEPTH);
          mb_count[b] = mb_count[b] - 1'b1;
        end
      end
    end
    replies_due.push_back(r);
  endtask

  task automatic report(input string what, input logic [PAY_W-1:0] want,
                        input logic [PAY_W-1:0] got);
    errors++;
    if (errors <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endtask

  task automatic check_reply(input logic [OUT_DATA_W-1:0] d);
    reply_t want;
    if (replies_due.size() == 0) begin
      report("result with no request pending, status", '0, d[2:0]);
    end else begin
      want = replies_due.pop_front();
      if (d[2:0] != want.status)      report("status", want.status, d[2:0]);
      if (d[34:3] != want.pid)        report("msg_src_pid", want.pid, d[34:3]);
      if (d[66:35] != want.tid)       report("msg_src_tid", want.tid, d[66:35]);
      if (d[70:67] != want.size)      report("msg_size", want.size, d[70:67]);
      if (d[134:71] != want.payload)  report("msg_payload", want.payload, d[134:71]);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < MAILBOXES; b++) begin
        mb_bound[b] = 1'b0;
        mb_slot[b]  = '0;
        mb_owner[b] = '0;
        empty_box(b);
      end
      replies_due.delete();
    end else begin
      // a result never belongs to a request taken on the same edge
      if (out_tvalid && out_tready) check_reply(out_tdata);
      if (in_tvalid && in_tready) predict_reply(in_tuser, in_tdata);
    end
    pending    <= replies_due.size();
    fail_count <= errors;
  end

endmodule

@@ tb/per_process_mailbox_queues_tb.sv @@
`timescale 1ns / 100ps
// Top of the mailbox queues testbench: clock, reset, request stimulus, result
// back-pressure, watchdog and verdict. Depends on ppmq_pkg, ppmq_checker, the block.
module per_process_mailbox_queues_tb;
  import ppmq_pkg::*;

  localparam int RANDOM_ITEMS   = 1250;
  localparam int HOLD_AFTER     = 400;    // requests sent before the long hold-off
  localparam int HOLD_CYCLES    = 300;    // length of the long hold-off
  localparam int WATCHDOG_LIMIT = 2000;   // quiet cycles tolerated, well past the hold-off
  localparam int DRAIN_CYCLES   = 2 * MAILBOXES + 8;  // wait before the verdict, past the worst-case scan

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // proc_slot, rcv_pid, receiver_alive, src_pid, src_tid, send_size,
  // send_payload, zero pad (lowest bit first)
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // cmd
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // status, msg_src_pid, msg_src_tid, msg_size, msg_payload, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;

  int mismatches;
  int pending;
  int quiet = 0;
  int requests_sent = 0;
  int burst_left = 0;

  // random-phase knobs: two busy slots and a send bias, so rings fill and drain
  logic [SLOT_W-1:0] hot_a, hot_b;
  int                send_pct;
  int                phase_left = 0;
  logic [PID_W-1:0]  slot_pid [16];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  per_process_mailbox_queues dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ppmq_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (mismatches),
    .pending    (pending)
  );

  // Offer one request and hold it until taken. Bursts keep tvalid high from one
  // request to the next; at a burst end tvalid drops and stays low for a random gap, so
  // it never gets two assignments on the same edge.
  task automatic issue(input logic cmd, input logic [SLOT_W-1:0] slot,
                       input logic [PID_W-1:0] rpid, input logic alive,
                       input logic [PID_W-1:0] spid, input logic [PID_W-1:0] stid,
                       input logic [SIZE_W-1:0] size, input logic [PAY_W-1:0] payload,
                       input bit is_last);
    in_tuser  <= cmd;
    in_tdata  <= {3'b000, payload, size, stid, spid, alive, rpid, slot};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
    if (is_last || burst_left == 0) begin
      in_tvalid <= 1'b0;
      // mostly short bursts, now and then a long back-to-back run
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Mostly well-formed traffic on the busy slots with live receivers and the
  // slot's current pid; a small share of noise: zero size, oversize, dead
  // receiver, and pid changes that re-tag and empty a box.
  task automatic random_request(input bit is_last);
    logic              cmd;
    logic [SLOT_W-1:0] slot;
    logic [PID_W-1:0]  rpid;
    logic [PID_W-1:0]  spid;
    logic [PID_W-1:0]  stid;
    logic              alive;
    logic [SIZE_W-1:0] size;
    int                roll;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 9) < 7) slot = $urandom_range(0, 1) ? hot_a : hot_b;
    else slot = $urandom_range(0, 15);
    cmd   = ($urandom_range(0, 99) < send_pct) ? CMD_SEND : CMD_RECV;
    alive = 1'b1;
    size  = $urandom_range(1, MSG_BYTES);
    spid  = ($urandom_range(0, 19) == 0) ? '0 : $urandom;
    stid  = ($urandom_range(0, 19) == 0) ? '0 : $urandom;
    if (roll < 2) begin
      size = '0;
    end else if (roll < 4) begin
      size = $urandom_range(MSG_BYTES + 1, 255);
    end else if (roll < 7) begin
      alive = 1'b0;
    end else if (roll < 9) begin
      slot_pid[slot] = $urandom;
    end
    rpid = slot_pid[slot];
    issue(cmd, slot, rpid, alive, spid, stid, size, {$urandom, $urandom}, is_last);
  endtask

  // Stimulus: reset, directed corner requests, then random phases.
  initial begin : stimulus
    logic [PID_W-1:0] pid_a;
    pid_a = 32'h0000_0001;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // receive on a fresh slot binds a box and finds it empty
    issue(CMD_RECV, 4'd0, pid_a, 1'b1, '0, '0, '0, '0, 1'b0);
    // send checks in order: zero size, too large, then dead receiver
    issue(CMD_SEND, 4'd0, pid_a, 1'b1, 32'h11, 32'h22, 8'd0, '1, 1'b0);
    issue(CMD_SEND, 4'd0, pid_a, 1'b1, 32'h11, 32'h22, 8'd9, '1, 1'b0);
    issue(CMD_SEND, 4'd0, pid_a, 1'b0, 32'h11, 32'h22, 8'd255, '1, 1'b0);
    issue(CMD_SEND, 4'd0, pid_a, 1'b0, 32'h11, 32'h22, 8'd8, '1, 1'b0);
    issue(CMD_SEND, 4'd0, pid_a, 1'b0, 32'h11, 32'h22, 8'd0, '1, 1'b0);
    issue(CMD_RECV, 4'd0, pid_a, 1'b0, '0, '0, '0, '0, 1'b0);
    // smallest and largest messages, all-ones and all-zero ids; short
    // messages must come back with the unused payload bytes cleared
    issue(CMD_SEND, 4'd0, pid_a, 1'b1, '0, '0, 8'd1, '1, 1'b0);
    issue(CMD_SEND, 4'd0, pid_a, 1'b1, '1, '1, 8'd8, '1, 1'b0);
    issue(CMD_SEND, 4'd0, pid_a, 1'b1, $urandom, $urandom, 8'd3,
          {$urandom, $urandom}, 1'b0);
    repeat (3) issue(CMD_RECV, 4'd0, pid_a, 1'b1, '0, '0, '0, '0, 1'b0);
    // pid change on the top slot empties and re-tags its box
    issue(CMD_SEND, 4'd15, '1, 1'b1, 32'h33, 32'h44, 8'd4, '1, 1'b0);
    issue(CMD_SEND, 4'd15, '0, 1'b1, 32'h55, 32'h66, 8'd2, '1, 1'b0);
    issue(CMD_RECV, 4'd15, '0, 1'b1, '0, '0, '0, '0, 1'b0);
    issue(CMD_RECV, 4'd15, '0, 1'b1, '0, '0, '0, '0, 1'b0);

    for (int s = 0; s < 16; s++) slot_pid[s] = $urandom;
    slot_pid[0]  = pid_a;
    slot_pid[15] = '0;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 160);
        hot_a      = $urandom_range(0, 15);
        hot_b      = $urandom_range(0, 15);
        case ($urandom_range(0, 2))
          0:       send_pct = 80;   // fill rings until full
          1:       send_pct = 25;   // drain them to empty
          default: send_pct = 50;
        endcase
      end
      phase_left--;
      random_request(n == RANDOM_ITEMS - 1);
    end

    // let the last request reach the scoreboard, then drain
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** per_process_mailbox_queues: PASSED **");
    end else begin
      $display("** per_process_mailbox_queues: FAILED **");
    end
    $finish;
  end

  // Result side: alternating stall patterns of random length, plus one long
  // hold-off while the sender keeps offering, so the block backs up.
  initial begin : result_side
    int  mode;
    int  span;
    bit  hold_done;
    hold_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        case (mode)
          0:       out_tready <= 1'b1;                          // no stalls
          1:       out_tready <= ($urandom_range(0, 1) == 1);   // coin flip
          2:       out_tready <= (k % 4 == 3);                  // one cycle in four
          default: out_tready <= ($urandom_range(0, 7) != 0);   // rare stalls
        endcase
      end
      if (!hold_done && requests_sent >= HOLD_AFTER) begin
        @(posedge clk);
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no handshake on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("** per_process_mailbox_queues: FAILED **");
        $finish;
      end
    end
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ppmq_pkg.sv
rtl/ppmq_ram.sv
rtl/per_process_mailbox_queues.sv
tb/ppmq_checker.sv
tb/per_process_mailbox_queues_tb.sv
